@@ sv/m2u_pkg.sv @@
// m2u_pkg: shared types and constants for the midi to usb-midi packetizer
// holds code index numbers, status byte codes and the encoder state struct
// no dependencies
package m2u_pkg;

	localparam logic [3:0] CIN_SYS_COMMON_2 = 4'h2;
	localparam logic [3:0] CIN_SYS_COMMON_3 = 4'h3;
	localparam logic [3:0] CIN_SYSEX_CONT   = 4'h4;
	localparam logic [3:0] CIN_SINGLE_END1  = 4'h5;
	localparam logic [3:0] CIN_SYSEX_END2   = 4'h6;
	localparam logic [3:0] CIN_SYSEX_END3   = 4'h7;
	localparam logic [3:0] CIN_REALTIME     = 4'hF;

	localparam logic [7:0] ST_SYSEX_START = 8'hF0;
	localparam logic [7:0] ST_MTC_QUARTER = 8'hF1;
	localparam logic [7:0] ST_SONG_POS    = 8'hF2;
	localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
	localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
	localparam logic [7:0] ST_REALTIME_LO = 8'hF8;

	localparam logic [7:0] HI_MASK  = 8'hF0;
	localparam logic [7:0] HI_PROG  = 8'hC0;
	localparam logic [7:0] HI_PRESS = 8'hD0;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_CABLE_NUMBER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINK_UP      = 2'd1;

	typedef struct packed {
		logic       in_sysex;
		logic [1:0] held_count;
		logic [1:0] needed_count;
		logic [7:0] held0;
		logic [7:0] held1;
		logic [7:0] open_status;
	} enc_state_t;

	typedef struct packed {
		logic [3:0] code_index;
		logic [7:0] first_data;
		logic [7:0] second_data;
		logic [7:0] third_data;
	} packet_t;

	localparam enc_state_t STATE_IDLE = '{
		in_sysex: 1'b0, held_count: 2'd0, needed_count: 2'd0,
		held0: 8'h00, held1: 8'h00, open_status: 8'h00
	};

endpackage

@@ sv/m2u_encoder.sv @@
// m2u_encoder: combinational next-state and packet logic for one midi byte
// depends on m2u_pkg for the state struct, packet struct and code constants
module m2u_encoder (
	input  logic                 link_up,
	input  logic [7:0]           midi_byte,
	input  logic                 last_in_batch,
	input  m2u_pkg::enc_state_t  cur,
	output m2u_pkg::enc_state_t  nxt,
	output logic                 emit,
	output m2u_pkg::packet_t     pkt
);

	logic [3:0] msg_cin;

	always_comb begin
		if (cur.open_status >= m2u_pkg::ST_SYSEX_START) begin
			msg_cin = (cur.open_status == m2u_pkg::ST_SONG_POS) ?
				m2u_pkg::CIN_SYS_COMMON_3 : m2u_pkg::CIN_SYS_COMMON_2;
		end else begin
			msg_cin = cur.open_status[7:4];
		end
	end

	always_comb begin
		nxt  = cur;
		emit = 1'b0;
		pkt  = '0;
		if (link_up) begin
			priority if (midi_byte >= m2u_pkg::ST_REALTIME_LO) begin
				emit = 1'b1;
				pkt.code_index = m2u_pkg::CIN_REALTIME;
				pkt.first_data = midi_byte;
			end else if (midi_byte == m2u_pkg::ST_SYSEX_START) begin
				nxt = m2u_pkg::STATE_IDLE;
				nxt.in_sysex = 1'b1;
				nxt.held0 = m2u_pkg::ST_SYSEX_START;
				nxt.held_count = 2'd1;
			end else if (midi_byte == m2u_pkg::ST_SYSEX_END) begin
				nxt  = m2u_pkg::STATE_IDLE;
				emit = 1'b1;
				if (cur.in_sysex && cur.held_count == 2'd1) begin
					pkt.code_index  = m2u_pkg::CIN_SYSEX_END2;
					pkt.first_data  = cur.held0;
					pkt.second_data = m2u_pkg::ST_SYSEX_END;
				end else if (cur.in_sysex && cur.held_count >= 2'd2) begin
					pkt.code_index  = m2u_pkg::CIN_SYSEX_END3;
					pkt.first_data  = cur.held0;
					pkt.second_data = cur.held1;
					pkt.third_data  = m2u_pkg::ST_SYSEX_END;
				end else begin
					pkt.code_index = m2u_pkg::CIN_SINGLE_END1;
					pkt.first_data = m2u_pkg::ST_SYSEX_END;
				end
			end else if (midi_byte >= m2u_pkg::ST_MTC_QUARTER) begin
				nxt = m2u_pkg::STATE_IDLE;
				if (midi_byte == m2u_pkg::ST_MTC_QUARTER ||
				    midi_byte == m2u_pkg::ST_SONG_SEL) begin
					nxt.open_status  = midi_byte;
					nxt.needed_count = 2'd1;
				end else if (midi_byte == m2u_pkg::ST_SONG_POS) begin
					nxt.open_status  = midi_byte;
					nxt.needed_count = 2'd2;
				end else begin
					emit = 1'b1;
					pkt.code_index = m2u_pkg::CIN_SINGLE_END1;
					pkt.first_data = midi_byte;
				end
			end else if (midi_byte[7]) begin
				nxt = m2u_pkg::STATE_IDLE;
				nxt.open_status = midi_byte;
				if ((midi_byte & m2u_pkg::HI_MASK) == m2u_pkg::HI_PROG ||
				    (midi_byte & m2u_pkg::HI_MASK) == m2u_pkg::HI_PRESS) begin
					nxt.needed_count = 2'd1;
				end else begin
					nxt.needed_count = 2'd2;
				end
			end else if (cur.in_sysex) begin
				if (cur.held_count >= 2'd2) begin
					emit = 1'b1;
					pkt.code_index  = m2u_pkg::CIN_SYSEX_CONT;
					pkt.first_data  = cur.held0;
					pkt.second_data = cur.held1;
					pkt.third_data  = midi_byte;
					nxt.held_count  = 2'd0;
					nxt.held0       = 8'h00;
					nxt.held1       = 8'h00;
				end else begin
					if (cur.held_count[0]) begin
						nxt.held1 = midi_byte;
					end else begin
						nxt.held0 = midi_byte;
					end
					nxt.held_count = 2'(cur.held_count + 2'd1);
				end
			end else if (cur.needed_count != 2'd0) begin
				if (cur.needed_count == 2'd1) begin
					nxt  = m2u_pkg::STATE_IDLE;
					emit = 1'b1;
					pkt.code_index  = msg_cin;
					pkt.first_data  = cur.open_status;
					pkt.second_data = midi_byte;
				end else if (cur.held_count == 2'd0) begin
					nxt.held0      = midi_byte;
					nxt.held_count = 2'd1;
				end else begin
					nxt  = m2u_pkg::STATE_IDLE;
					emit = 1'b1;
					pkt.code_index  = msg_cin;
					pkt.first_data  = cur.open_status;
					pkt.second_data = cur.held0;
					pkt.third_data  = midi_byte;
				end
			end

			// batch end flushes a partial sysex chunk
			if (last_in_batch && !emit && nxt.in_sysex && nxt.held_count != 2'd0) begin
				emit = 1'b1;
				pkt.code_index  = m2u_pkg::CIN_SYSEX_CONT;
				pkt.first_data  = nxt.held0;
				pkt.second_data = (nxt.held_count >= 2'd2) ? nxt.held1 : 8'h00;
				pkt.third_data  = 8'h00;
				nxt.held_count  = 2'd0;
				nxt.held0       = 8'h00;
				nxt.held1       = 8'h00;
			end
		end
	end

endmodule

@@ sv/midi_to_usb_midi_packetizer.sv @@
// midi_to_usb_midi_packetizer: raw midi bytes in, 4-byte usb-midi event packets out
// pkt_valid: set as a message's last byte moves from the byte register to the result register
// throughput: one byte per cycle; a stalled packet holds an emitting byte in the byte register
// reset: arst_n clears parser state, cable number, link_up and all valid flags
// depends on m2u_pkg and m2u_encoder
module midi_to_usb_midi_packetizer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             midi_valid,
	output logic                             midi_stall,
	input  logic [7:0]                       midi_byte,
	input  logic                             last_in_batch,
	output logic                             pkt_valid,
	input  logic                             pkt_stall,
	output logic [3:0]                       cable,
	output logic [3:0]                       code_index,
	output logic [7:0]                       first_data,
	output logic [7:0]                       second_data,
	output logic [7:0]                       third_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [m2u_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [7:0]                       cfg_data
);

	logic [3:0]          cable_number_q;
	logic                link_up_q;

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                last_s1;

	m2u_pkg::enc_state_t state_q;
	m2u_pkg::enc_state_t state_nxt;
	logic                emit;
	m2u_pkg::packet_t    pkt;

	logic                out_valid_q;
	logic [3:0]          out_cable_q;
	m2u_pkg::packet_t    out_pkt_q;

	logic                out_free;
	logic                fire;

	assign cfg_ready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cable_number_q <= 4'd0;
			link_up_q      <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == m2u_pkg::CFG_CABLE_NUMBER) begin
				cable_number_q <= cfg_data[3:0];
			end else if (cfg_index == m2u_pkg::CFG_LINK_UP) begin
				link_up_q <= cfg_data[0];
			end
		end
	end

	m2u_encoder u_enc (
		.link_up       (link_up_q),
		.midi_byte     (byte_s1),
		.last_in_batch (last_s1),
		.cur           (state_q),
		.nxt           (state_nxt),
		.emit          (emit),
		.pkt           (pkt)
	);

	assign out_free   = !out_valid_q || !pkt_stall;
	assign fire       = valid_s1 && (out_free || !emit);
	assign midi_stall = valid_s1 && !fire;

	// input word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!midi_stall) begin
			valid_s1 <= midi_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (midi_valid && !midi_stall) begin
			byte_s1 <= midi_byte;
			last_s1 <= last_in_batch;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= m2u_pkg::STATE_IDLE;
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (!pkt_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			out_cable_q <= cable_number_q;
			out_pkt_q   <= pkt;
		end
	end

	assign pkt_valid   = out_valid_q;
	assign cable       = out_cable_q;
	assign code_index  = out_pkt_q.code_index;
	assign first_data  = out_pkt_q.first_data;
	assign second_data = out_pkt_q.second_data;
	assign third_data  = out_pkt_q.third_data;

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		midi_stall |-> valid_s1)
		else $error("input stalled with empty word register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && pkt_stall) |=> (out_valid_q && $stable(out_pkt_q)))
		else $error("pending packet lost or changed");

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.held_count != 2'd3 && state_q.needed_count != 2'd3)
		else $error("held or needed count out of range");

	a_sysex_no_msg: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.in_sysex |-> (state_q.needed_count == 2'd0))
		else $error("sysex and channel message open together");

	a_new_pkt_from_fire: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(fire && emit))
		else $error("packet appeared without an encoded word");

endmodule
